FILE: rtl/read_pair_overlap_trimmer_defines.svh
// Assertion macros used by the trimmer sequencer (rpot_seq).
`ifndef READ_PAIR_OVERLAP_TRIMMER_DEFINES_SVH
`define READ_PAIR_OVERLAP_TRIMMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPOT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rpot check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPOT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rpot check failed");

`endif

FILE: rtl/rpot_pkg.sv
package rpot_pkg;

	localparam int RPOT_MAX_READ_LEN = 256;
	localparam int MOL_W = 9;
	localparam logic [MOL_W-1:0] MOL_RESET = 9'd30;

	localparam logic [1:0] ACT_READ1 = 2'd0;
	localparam logic [1:0] ACT_READ2 = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	localparam logic [2:0] BASE_N = 3'd4;

	typedef struct packed {
		logic wr;
		logic clr;
		logic [2:0] base;
	} store_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RSTART,
		ST_PCHK,
		ST_SEED_RD,
		ST_SEED_CMP,
		ST_HIT,
		ST_PRE_RD,
		ST_PRE_CMP,
		ST_TAIL_CHK,
		ST_TAIL_RD,
		ST_TAIL_CMP,
		ST_RND_END,
		ST_DONE
	} rpot_state_t;

	function automatic logic [2:0] rpot_norm(input logic [2:0] b);
		return (b > BASE_N) ? BASE_N : b;
	endfunction

	function automatic logic [2:0] rpot_comp(input logic [2:0] b);
		return (b >= BASE_N) ? BASE_N : 3'(3'd3 - b);
	endfunction

endpackage

FILE: rtl/rpot_store.sv
module rpot_store import rpot_pkg::*; #(
	parameter int MAX_READ_LEN = RPOT_MAX_READ_LEN
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  store_req_t                         req,
	input  logic [$clog2(MAX_READ_LEN)-1:0]    rd_addr,
	output logic [2:0]                         rd_base,
	output logic [$clog2(MAX_READ_LEN+1)-1:0]  count
);

	localparam int AW = $clog2(MAX_READ_LEN);
	localparam int CW = $clog2(MAX_READ_LEN + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_READ_LEN);

	logic [2:0] mem [MAX_READ_LEN];
	logic [CW-1:0] count_q;
	logic [2:0] rd_base_q;

	always_ff @(posedge clk) begin
		if (req.wr && (count_q < MAXC)) begin
			mem[count_q[AW-1:0]] <= req.base;
		end
		rd_base_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req.clr) begin
			count_q <= '0;
		end else if (req.wr && (count_q < MAXC)) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign rd_base = rd_base_q;
	assign count = count_q;

endmodule

FILE: rtl/rpot_seq.sv
`include "read_pair_overlap_trimmer_defines.svh"

module rpot_seq import rpot_pkg::*; #(
	parameter int MAX_READ_LEN = RPOT_MAX_READ_LEN
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [1:0]                         s_action,
	input  logic [2:0]                         s_base,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [MOL_W-1:0]                   cfg_data,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [15:0]                        m_tdata,
	output store_req_t                         req1,
	output store_req_t                         req2,
	output logic [$clog2(MAX_READ_LEN)-1:0]    rd1_addr,
	output logic [$clog2(MAX_READ_LEN)-1:0]    rd2_addr,
	input  logic [2:0]                         rd1_base,
	input  logic [2:0]                         rd2_base,
	input  logic [$clog2(MAX_READ_LEN+1)-1:0]  cnt1,
	input  logic [$clog2(MAX_READ_LEN+1)-1:0]  cnt2
);

	localparam int AW = $clog2(MAX_READ_LEN);
	localparam int CW = $clog2(MAX_READ_LEN + 1);
	localparam int IW = ((CW > MOL_W) ? CW : MOL_W) + 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_READ_LEN);

	rpot_state_t state_q, state_d;

	logic [MOL_W-1:0] mol_q;
	logic ovf_q;
	logic m_tvalid_q;
	logic [15:0] m_tdata_q;

	logic round_q;
	logic [IW-1:0] s_q, off_q, p_q, a_q, b_q;
	logic err_q;
	logic merged_q, hit_round_q;
	logic [MOL_W-1:0] ovl_q;

	logic [IW-1:0] l1, l2, mol, ovl, rc_addr;
	logic accept, out_free, mis, seed_last, pre_last;

	assign l1 = IW'(cnt1);
	assign l2 = IW'(cnt2);
	assign mol = IW'(mol_q);
	assign ovl = l2 - p_q + off_q;
	assign rc_addr = l2 - IW'(1) - a_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign mis = (b_q >= l1) || (rd1_base != rpot_comp(rd2_base));
	assign seed_last = (b_q + IW'(1)) == (off_q + s_q);
	assign pre_last = (b_q + IW'(1)) == off_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (s_action == ACT_FINISH)) begin
					state_d = ST_RSTART;
				end
			end
			ST_RSTART: state_d = ST_PCHK;
			ST_PCHK: begin
				if ((p_q + s_q) > l2) begin
					state_d = ST_RND_END;
				end else if (s_q == '0) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_SEED_RD;
				end
			end
			ST_SEED_RD: state_d = ST_SEED_CMP;
			ST_SEED_CMP: begin
				if (mis) begin
					state_d = ST_PCHK;
				end else if (seed_last) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_SEED_RD;
				end
			end
			ST_HIT: begin
				if ((ovl < mol) || (p_q < off_q)) begin
					state_d = ST_RND_END;
				end else if (off_q == '0) begin
					state_d = ST_TAIL_CHK;
				end else begin
					state_d = ST_PRE_RD;
				end
			end
			ST_PRE_RD: state_d = ST_PRE_CMP;
			ST_PRE_CMP: begin
				if (mis && err_q) begin
					state_d = ST_PCHK;
				end else if (pre_last) begin
					state_d = ST_TAIL_CHK;
				end else begin
					state_d = ST_PRE_RD;
				end
			end
			ST_TAIL_CHK: begin
				if (a_q >= l2) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_TAIL_RD;
				end
			end
			ST_TAIL_RD: state_d = ST_TAIL_CMP;
			ST_TAIL_CMP: begin
				if (mis && err_q) begin
					state_d = ST_PCHK;
				end else begin
					state_d = ST_TAIL_CHK;
				end
			end
			ST_RND_END: begin
				if (round_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RSTART;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		accept = s_tvalid && s_tready;
		cfg_ready = 1'b1;
		req1.wr = accept && (s_action == ACT_READ1);
		req2.wr = accept && (s_action == ACT_READ2);
		req1.base = rpot_norm(s_base);
		req2.base = rpot_norm(s_base);
		req1.clr = (state_q == ST_DONE) && out_free;
		req2.clr = (state_q == ST_DONE) && out_free;
		rd1_addr = b_q[AW-1:0];
		rd2_addr = rc_addr[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mol_q <= MOL_RESET;
			ovf_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				mol_q <= cfg_data;
			end
			if ((req1.wr && (cnt1 == MAXC)) || (req2.wr && (cnt2 == MAXC))) begin
				ovf_q <= 1'b1;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				round_q <= 1'b0;
				s_q <= IW'(mol_q[MOL_W-1:1]);
			end
			ST_RSTART: begin
				off_q <= round_q ? s_q : '0;
				p_q <= '0;
			end
			ST_PCHK: begin
				a_q <= p_q;
				b_q <= off_q;
			end
			ST_SEED_CMP: begin
				if (mis) begin
					p_q <= p_q + IW'(1);
				end else begin
					a_q <= a_q + IW'(1);
					b_q <= b_q + IW'(1);
				end
			end
			ST_HIT: begin
				err_q <= 1'b0;
				if (off_q == '0) begin
					a_q <= p_q + s_q;
					b_q <= off_q + s_q;
				end else begin
					a_q <= p_q - off_q;
					b_q <= '0;
				end
			end
			ST_PRE_CMP: begin
				if (mis && err_q) begin
					p_q <= p_q + IW'(1);
				end else begin
					err_q <= err_q | mis;
					if (pre_last) begin
						a_q <= p_q + s_q;
						b_q <= off_q + s_q;
					end else begin
						a_q <= a_q + IW'(1);
						b_q <= b_q + IW'(1);
					end
				end
			end
			ST_TAIL_CHK: begin
				if (a_q >= l2) begin
					merged_q <= 1'b1;
					ovl_q <= ovl[MOL_W-1:0];
					hit_round_q <= round_q;
				end
			end
			ST_TAIL_CMP: begin
				if (mis && err_q) begin
					p_q <= p_q + IW'(1);
				end else begin
					err_q <= err_q | mis;
					a_q <= a_q + IW'(1);
					b_q <= b_q + IW'(1);
				end
			end
			ST_RND_END: begin
				round_q <= 1'b1;
				if (round_q) begin
					merged_q <= 1'b0;
					ovl_q <= '0;
					hit_round_q <= 1'b0;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {4'b0, ovf_q, hit_round_q, ovl_q, merged_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`RPOT_ASSERT_NEXT(a_result_load, clk, arst_n, (state_q == ST_DONE) && out_free, m_tvalid_q && (state_q == ST_IDLE))
	`RPOT_ASSERT_IMP(a_seed_range, clk, arst_n, state_q == ST_SEED_RD, (p_q + s_q) <= l2)
	`RPOT_ASSERT_IMP(a_tail_range, clk, arst_n, state_q == ST_TAIL_RD, a_q < l2)
	`RPOT_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, (cnt1 <= MAXC) && (cnt2 <= MAXC))

endmodule

FILE: rtl/read_pair_overlap_trimmer.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: action; tdata: base
// m_*       out  m_tvalid/m_tready    tdata: merged, overlap_length, seed_round, length_overflow
// cfg_*     in   cfg_valid/cfg_ready  min_overlap_length
//
// Base beats load only while the sequencer is idle. A finish beat walks both stores
// through one read port per store and one shared base comparator, with a read step
// and then a compare step for each base pair at each candidate position of a round.
// Reset clears counts, overflow flag, output valid and loads min_overlap_length = 30.
// The result sits in an output register; a stalled m_tready holds only the next finish.
module read_pair_overlap_trimmer import rpot_pkg::*; #(
	parameter int MAX_READ_LEN = RPOT_MAX_READ_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [2:0] base
	input  logic [1:0]        s_tuser,   // [1:0] action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [0] merged, [9:1] overlap_length, [10] seed_round,
	                                     // [11] length_overflow
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MOL_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_READ_LEN);
	localparam int CW = $clog2(MAX_READ_LEN + 1);

	store_req_t req1, req2;
	logic [AW-1:0] rd1_addr, rd2_addr;
	logic [2:0] rd1_base, rd2_base;
	logic [CW-1:0] cnt1, cnt2;

	rpot_store #(.MAX_READ_LEN(MAX_READ_LEN)) u_store1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req1),
		.rd_addr (rd1_addr),
		.rd_base (rd1_base),
		.count   (cnt1)
	);

	rpot_store #(.MAX_READ_LEN(MAX_READ_LEN)) u_store2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req2),
		.rd_addr (rd2_addr),
		.rd_base (rd2_base),
		.count   (cnt2)
	);

	rpot_seq #(.MAX_READ_LEN(MAX_READ_LEN)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_action  (s_tuser),
		.s_base    (s_tdata[2:0]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.req1      (req1),
		.req2      (req2),
		.rd1_addr  (rd1_addr),
		.rd2_addr  (rd2_addr),
		.rd1_base  (rd1_base),
		.rd2_base  (rd2_base),
		.cnt1      (cnt1),
		.cnt2      (cnt2)
	);

endmodule
